// ----- rtl/sit_pkg.sv -----
// ----------------------------------------------------------------------------
// Segment intersection test package
// Coordinate widths, intermediate types, decision codes and the product helpers
// shared by the segment intersection test core.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int EXT_WIDTH   = COORD_WIDTH + 2;
  localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
  localparam int CROSS_WIDTH = PROD_WIDTH + 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [EXT_WIDTH-1:0]   ext_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [CROSS_WIDTH-1:0] cross_t;

  typedef enum logic [1:0] {
    DEC_BOX       = 2'd0,
    DEC_PARALLEL  = 2'd1,
    DEC_COLLINEAR = 2'd2,
    DEC_GENERAL   = 2'd3
  } decided_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_end_x;
    coord_t b_end_y;
  } seg_pair_t;

  typedef struct packed {
    logic     crosses;
    decided_t decided_by;
  } verdict_t;

  function automatic prod_t smul(diff_t a, diff_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  function automatic cross_t cross2(diff_t ax, diff_t ay, diff_t bx, diff_t by);
    return cross_t'(smul(ax, by)) - cross_t'(smul(ay, bx));
  endfunction

endpackage

// ----- rtl/sit_in_if.sv -----
// ----------------------------------------------------------------------------
// Segment pair channel
// Valid/ready channel carrying the four endpoints of two segments.
// ----------------------------------------------------------------------------
interface sit_in_if;
  import sit_pkg::*;

  logic   valid;
  logic   ready;
  coord_t a_start_x;
  coord_t a_start_y;
  coord_t a_end_x;
  coord_t a_end_y;
  coord_t b_start_x;
  coord_t b_start_y;
  coord_t b_end_x;
  coord_t b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );

  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );

endinterface

// ----- rtl/sit_out_if.sv -----
// ----------------------------------------------------------------------------
// Intersection verdict channel
// Valid/ready channel carrying the crossing flag and the deciding case.
// ----------------------------------------------------------------------------
interface sit_out_if;

  logic       valid;
  logic       ready;
  logic       crosses;
  logic [1:0] decided_by;

  modport source (
    output valid, crosses, decided_by,
    input  ready
  );

  modport sink (
    input  valid, crosses, decided_by,
    output ready
  );

endinterface

// ----- rtl/sit_eval.sv -----
// ----------------------------------------------------------------------------
// Segment intersection evaluator
// Exact, division-free decision for one pair of closed segments: box
// rejection, parallel and collinear handling, and the general parameter test.
// ----------------------------------------------------------------------------
module sit_eval (
  input  sit_pkg::seg_pair_t pair,
  output sit_pkg::verdict_t  verdict
);
  import sit_pkg::*;

  coord_t a_min_x, a_max_x, a_min_y, a_max_y;
  coord_t b_min_x, b_max_x, b_min_y, b_max_y;
  logic   box_reject;
  diff_t  v1x, v1y, v2x, v2y, vdx, vdy, u1_x, u1_y;
  diff_t  u0_sel, u1_sel, len_sel;
  diff_t  abs_v1x, abs_v1y;
  ext_t   u0_e, u1_e, len_e, lo_e, hi_e;
  cross_t d, n1, n2;
  logic   a_is_point, n1_ok, n2_ok, overlap;

  always_comb begin
    a_min_x = (pair.a_start_x < pair.a_end_x) ? pair.a_start_x : pair.a_end_x;
    a_max_x = (pair.a_start_x < pair.a_end_x) ? pair.a_end_x : pair.a_start_x;
    a_min_y = (pair.a_start_y < pair.a_end_y) ? pair.a_start_y : pair.a_end_y;
    a_max_y = (pair.a_start_y < pair.a_end_y) ? pair.a_end_y : pair.a_start_y;
    b_min_x = (pair.b_start_x < pair.b_end_x) ? pair.b_start_x : pair.b_end_x;
    b_max_x = (pair.b_start_x < pair.b_end_x) ? pair.b_end_x : pair.b_start_x;
    b_min_y = (pair.b_start_y < pair.b_end_y) ? pair.b_start_y : pair.b_end_y;
    b_max_y = (pair.b_start_y < pair.b_end_y) ? pair.b_end_y : pair.b_start_y;
    box_reject = (a_max_x < b_min_x) || (b_max_x < a_min_x) ||
                 (a_max_y < b_min_y) || (b_max_y < a_min_y);

    v1x  = diff_t'(pair.a_end_x) - diff_t'(pair.a_start_x);
    v1y  = diff_t'(pair.a_end_y) - diff_t'(pair.a_start_y);
    v2x  = diff_t'(pair.b_end_x) - diff_t'(pair.b_start_x);
    v2y  = diff_t'(pair.b_end_y) - diff_t'(pair.b_start_y);
    vdx  = diff_t'(pair.a_start_x) - diff_t'(pair.b_start_x);
    vdy  = diff_t'(pair.a_start_y) - diff_t'(pair.b_start_y);
    u1_x = diff_t'(pair.b_end_x) - diff_t'(pair.a_start_x);
    u1_y = diff_t'(pair.b_end_y) - diff_t'(pair.a_start_y);

    d  = cross2(v1x, v1y, v2x, v2y);
    n1 = cross2(v2x, v2y, vdx, vdy);
    n2 = cross2(v1x, v1y, vdx, vdy);

    // The segments meet when both parameters n/d lie in the closed unit range.
    if (d[CROSS_WIDTH-1]) begin
      n1_ok = !(n1 > cross_t'(0)) && (n1 >= d);
      n2_ok = !(n2 > cross_t'(0)) && (n2 >= d);
    end else begin
      n1_ok = !n1[CROSS_WIDTH-1] && (n1 <= d);
      n2_ok = !n2[CROSS_WIDTH-1] && (n2 <= d);
    end

    // Collinear case: project onto the dominant axis of the first segment.
    abs_v1x = v1x[DIFF_WIDTH-1] ? -v1x : v1x;
    abs_v1y = v1y[DIFF_WIDTH-1] ? -v1y : v1y;
    if ($unsigned(abs_v1x) > $unsigned(abs_v1y)) begin
      u0_sel  = -vdx;
      u1_sel  = u1_x;
      len_sel = v1x;
    end else begin
      u0_sel  = -vdy;
      u1_sel  = u1_y;
      len_sel = v1y;
    end
    if (len_sel[DIFF_WIDTH-1]) begin
      u0_e  = -ext_t'(u0_sel);
      u1_e  = -ext_t'(u1_sel);
      len_e = -ext_t'(len_sel);
    end else begin
      u0_e  = ext_t'(u0_sel);
      u1_e  = ext_t'(u1_sel);
      len_e = ext_t'(len_sel);
    end
    lo_e    = (u0_e < u1_e) ? u0_e : u1_e;
    hi_e    = (u0_e < u1_e) ? u1_e : u0_e;
    overlap = (lo_e <= len_e) && !hi_e[EXT_WIDTH-1];

    a_is_point = (v1x == diff_t'(0)) && (v1y == diff_t'(0));

    if (box_reject) begin
      verdict.crosses    = 1'b0;
      verdict.decided_by = DEC_BOX;
    end else if (d == cross_t'(0)) begin
      if (a_is_point) begin
        verdict.crosses    = (n1 == cross_t'(0));
        verdict.decided_by = DEC_COLLINEAR;
      end else if (n2 != cross_t'(0)) begin
        verdict.crosses    = 1'b0;
        verdict.decided_by = DEC_PARALLEL;
      end else begin
        verdict.crosses    = overlap;
        verdict.decided_by = DEC_COLLINEAR;
      end
    end else begin
      verdict.crosses    = n1_ok && n2_ok;
      verdict.decided_by = DEC_GENERAL;
    end
  end

endmodule

// ----- rtl/segment_intersection_test_core.sv -----
// ----------------------------------------------------------------------------
// Segment intersection test core
// Streams pairs of closed 2D segments and reports whether each pair shares a
// point, together with the case that decided it.
// ----------------------------------------------------------------------------
//   Channel   Direction  Carries
//   in_chan   sink       eight signed endpoint coordinates of two segments
//   out_chan  source     crosses flag and two-bit decided_by code
//
// Each pair passes the input register and then the result register before its
// result shows on out_chan, and one pair can be taken in every cycle while out_chan is not stalled.
// The depth is set by the input register and the result register, with the
// three cross products and all comparisons between them.
// Reset clears both valid flags; the payload registers are not reset.
// A stalled result holds while the input register, if empty, still takes one more pair.
// ----------------------------------------------------------------------------
module segment_intersection_test_core (
  input  logic      clk,
  input  logic      rst_n,
  sit_in_if.sink    in_chan,
  sit_out_if.source out_chan
);
  import sit_pkg::*;

  seg_pair_t pair_r;
  logic      s1_valid_r;
  logic      out_valid_r;
  verdict_t  verdict_r;
  verdict_t  verdict_nxt;
  logic      out_adv;
  logic      s1_adv;

  sit_eval u_eval (
    .pair    (pair_r),
    .verdict (verdict_nxt)
  );

  assign out_adv = !out_valid_r || out_chan.ready;
  assign s1_adv  = !s1_valid_r || out_adv;

  assign in_chan.ready       = s1_adv;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.crosses    = verdict_r.crosses;
  assign out_chan.decided_by = verdict_r.decided_by;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= in_chan.valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_chan.valid) begin
      pair_r.a_start_x <= in_chan.a_start_x;
      pair_r.a_start_y <= in_chan.a_start_y;
      pair_r.a_end_x   <= in_chan.a_end_x;
      pair_r.a_end_y   <= in_chan.a_end_y;
      pair_r.b_start_x <= in_chan.b_start_x;
      pair_r.b_start_y <= in_chan.b_start_y;
      pair_r.b_end_x   <= in_chan.b_end_x;
      pair_r.b_end_y   <= in_chan.b_end_y;
    end
    if (out_adv && s1_valid_r) begin
      verdict_r <= verdict_nxt;
    end
  end

  // A transfer is never taken while both the input and the result registers are full and the result is stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |-> !(s1_valid_r && out_valid_r && !out_chan.ready))
    else $error("input transfer taken with the pipeline full and stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> s1_valid_r)
    else $error("accepted pair lost from the input register");

  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_chan.ready) |=> s1_valid_r)
    else $error("pending pair dropped during an output stall");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.decided_by == DEC_BOX ||
                        out_chan.decided_by == DEC_PARALLEL)) |-> !out_chan.crosses)
    else $error("rejected pair reported as crossing");

  assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("result valid straight after reset");

endmodule
